/* hdl/wbps_pkg.sv */
// wbps_pkg: types and constants shared by the wildcard byte pattern search unit
// register index codes, per-cell control bundle, result record
// no dependencies

package wbps_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW      = 3'd0,
		REG_PAT_MID_LOW  = 3'd1,
		REG_PAT_MID_HIGH = 3'd2,
		REG_PAT_HIGH     = 3'd3,
		REG_WILDCARD     = 3'd4,
		REG_LENGTH       = 3'd5,
		REG_BASE         = 3'd6
	} cfg_reg_t;

	// positions backed by the pattern and wildcard registers
	localparam int CFG_POSITIONS = 32;
	localparam int PATTERN_BITS  = CFG_POSITIONS * 8;
	localparam int LENGTH_W      = 6;
	// wide enough for the length register and for any pattern up to 64 positions
	localparam int LEN_EXT_W     = 7;
	localparam int OFFSET_W      = 32;
	localparam int RESULT_ADDR_W = 32;

	// control that every cell of the chain sees
	typedef struct packed {
		logic step;    // item taken and scan still live
		logic active;  // position lies inside the pattern length
		logic tail;    // position is the last one of the pattern
		logic wild;    // position matches any byte
	} wbps_cell_ctrl_t;

	typedef struct packed {
		logic                     found;
		logic [RESULT_ADDR_W-1:0] address;
	} wbps_result_t;

endpackage

/* hdl/wildcard_byte_pattern_search_unit.sv */
// wildcard_byte_pattern_search_unit: top level of the wildcard byte pattern search
// configuration registers, chain of wbps_cell positions, scan state, wbps_out_buf
// depends on wbps_pkg, wbps_cell, wbps_out_buf
//
// usage
//   configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
//   high and one register is written per transfer. write only while no scan is in flight.
//   bytes: data_valid/data_stall carry data_byte, first_of_scan and last_of_scan. a
//   transfer with first_of_scan clears the offset and the partial matches and starts a
//   new scan with that byte at offset zero.
//   results: result_valid/result_stall carry match_found and match_address. each scan
//   reports once, at the first full match or, failing that, at its last byte; bytes
//   after the report are dropped until the next first_of_scan.
//   output: a byte's result is registered in the wbps_out_buf output register, or in its
//   skid entry while result_stall holds. throughput: one byte per cycle unless data_stall
//   is high; each position compares its pattern byte and takes its neighbor's bit at once.
//   stall: results go into a two-entry buffer; data_stall rises only when both entries
//   hold results, so bytes keep flowing while one result waits on result_stall.
//   reset: all configuration registers, partial matches, the offset and the buffer clear.

module wildcard_byte_pattern_search_unit
	import wbps_pkg::*;
#(
	parameter int MAX_PATTERN_LEN = 32,
	parameter int ADDRESS_BITS    = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	// byte stream
	input  logic                     data_valid,
	output logic                     data_stall,
	input  logic [7:0]               data_byte,
	input  logic                     first_of_scan,
	input  logic                     last_of_scan,
	// results
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic                     match_found,
	output logic [RESULT_ADDR_W-1:0] match_address
);

	// address bits kept in a report, and the mask that keeps them
	localparam int KEPT_BITS = (ADDRESS_BITS < RESULT_ADDR_W) ? ADDRESS_BITS : RESULT_ADDR_W;
	localparam logic [RESULT_ADDR_W-1:0] ADDR_MASK =
		RESULT_ADDR_W'(({(RESULT_ADDR_W+1){1'b0}} | 1) << KEPT_BITS) - RESULT_ADDR_W'(1);

	// configuration registers
	logic [PATTERN_BITS-1:0]   pattern_q;
	logic [CFG_POSITIONS-1:0]  wildcard_q;
	logic [LENGTH_W-1:0]       length_q;
	logic [RESULT_ADDR_W-1:0]  base_q;

	// scan state
	logic [OFFSET_W-1:0]       offset_q;
	logic                      finished_q;

	logic                      accept;
	logic                      live;
	logic [LEN_EXT_W-1:0]      eff_len;
	logic [OFFSET_W-1:0]       cur_off;
	logic [MAX_PATTERN_LEN-1:0] chain;
	logic [MAX_PATTERN_LEN-1:0] hits;
	logic                      hit_any;
	logic [RESULT_ADDR_W-1:0]  start_addr;
	logic                      res_valid;
	wbps_result_t              res;
	wbps_result_t              out_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q  <= '0;
			wildcard_q <= '0;
			length_q   <= '0;
			base_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PAT_LOW:      pattern_q[63:0]    <= cfg_data;
				REG_PAT_MID_LOW:  pattern_q[127:64]  <= cfg_data;
				REG_PAT_MID_HIGH: pattern_q[191:128] <= cfg_data;
				REG_PAT_HIGH:     pattern_q[255:192] <= cfg_data;
				REG_WILDCARD:     wildcard_q         <= cfg_data[CFG_POSITIONS-1:0];
				REG_LENGTH:       length_q           <= cfg_data[LENGTH_W-1:0];
				REG_BASE:         base_q             <= cfg_data[RESULT_ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// lengths above the chain size are clamped to the chain
	always_comb begin
		if ({1'b0, length_q} > LEN_EXT_W'(MAX_PATTERN_LEN)) begin
			eff_len = LEN_EXT_W'(MAX_PATTERN_LEN);
		end else begin
			eff_len = {1'b0, length_q};
		end
	end

	assign accept  = data_valid & ~data_stall;
	// a scan is live unless it already reported; a new scan always is
	assign live    = accept & (first_of_scan | ~finished_q);
	assign cur_off = first_of_scan ? '0 : offset_q;

	// chain of cells, position 0 always sees a fresh candidate
	for (genvar i = 0; i < MAX_PATTERN_LEN; i++) begin : g_cell
		wbps_cell_ctrl_t ctrl;
		logic            link_in;
		logic [7:0]      pat_byte;

		if (i == 0) begin : g_head
			assign link_in = 1'b1;
		end else begin : g_link
			// a new scan drops all partial matches
			assign link_in = ~first_of_scan & chain[i-1];
		end

		if (i < CFG_POSITIONS) begin : g_cfg
			assign pat_byte  = pattern_q[8*i +: 8];
			assign ctrl.wild = wildcard_q[i];
		end else begin : g_fixed
			// positions past the registers: byte zero, never wild
			assign pat_byte  = 8'h00;
			assign ctrl.wild = 1'b0;
		end

		assign ctrl.step   = live;
		assign ctrl.active = LEN_EXT_W'(i) < eff_len;
		assign ctrl.tail   = LEN_EXT_W'(i) == (eff_len - LEN_EXT_W'(1));

		wbps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.link_in  (link_in),
			.data_byte(data_byte),
			.pat_byte (pat_byte),
			.link_out (chain[i]),
			.hit      (hits[i])
		);
	end

	assign hit_any = |hits;

	// match starts length-1 bytes before the current one
	assign start_addr = base_q + cur_off - RESULT_ADDR_W'(eff_len - LEN_EXT_W'(1));

	assign res_valid   = live & (hit_any | last_of_scan);
	assign res.found   = hit_any;
	assign res.address = hit_any ? (start_addr & ADDR_MASK) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			finished_q <= 1'b0;
		end else if (live) begin
			offset_q   <= cur_off + OFFSET_W'(1);
			finished_q <= res_valid;
		end
	end

	wbps_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.full     (data_stall),
		.out_valid(result_valid),
		.out_stall(result_stall),
		.out_data (out_data)
	);

	assign match_found   = out_data.found;
	assign match_address = out_data.address;

	// a report closes the scan
	a_report_closes_scan: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> finished_q)
		else $error("scan not closed after its report");

	// a found report needs a nonzero pattern length
	a_found_needs_length: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.found) |-> (eff_len != '0))
		else $error("match reported with zero pattern length");

	// byte side only stalls while a result is waiting at the output
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> result_valid)
		else $error("byte stall without a pending result");

	// a finished scan ignores bytes until the next start
	a_finished_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && finished_q && !first_of_scan) |=> $stable(offset_q))
		else $error("offset moved after the scan reported");

endmodule

/* hdl/wbps_cell.sv */
// wbps_cell: one pattern position of the shift-and chain
// holds one partial match bit and passes it to the next position
// depends on wbps_pkg

module wbps_cell
	import wbps_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  wbps_cell_ctrl_t ctrl,
	input  logic            link_in,
	input  logic [7:0]      data_byte,
	input  logic [7:0]      pat_byte,
	output logic            link_out,
	output logic            hit
);

	logic match_q;
	logic match_d;

	// prefix up to the previous position matched and this position accepts the byte
	assign match_d = link_in & ctrl.active & (ctrl.wild | (pat_byte == data_byte));
	assign hit      = ctrl.tail & match_d;
	assign link_out = match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.step) begin
			match_q <= match_d;
		end
	end

endmodule

/* hdl/wbps_out_buf.sv */
// wbps_out_buf: two-entry result buffer, output register plus skid entry
// lets the scan take bytes while a result waits on a stalled receiver
// depends on wbps_pkg

module wbps_out_buf
	import wbps_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  wbps_result_t push_data,
	output logic         full,
	output logic         out_valid,
	input  logic         out_stall,
	output wbps_result_t out_data
);

	logic         head_valid_q;
	wbps_result_t head_q;
	logic         skid_valid_q;
	wbps_result_t skid_q;
	logic         head_free;

	assign head_free = ~head_valid_q | ~out_stall;
	assign full      = skid_valid_q;
	assign out_valid = head_valid_q;
	assign out_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (head_free) begin
			if (skid_valid_q) begin
				head_valid_q <= 1'b1;
				skid_valid_q <= push;
			end else begin
				head_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (head_free) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
				skid_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule
